>>> design/chl_pkg.sv
// Shared types and constants for the chiller hysteresis and lockout controller.
`timescale 1ns / 1ps
package chl_pkg;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned TIMER_W = 32;
  localparam int unsigned TEMP_W = 12;
  localparam int unsigned BAND_W = 11;
  localparam int unsigned DELTA_W = 16;
  localparam int unsigned FAN_W = 8;
  // thresholds need room for setpoint plus or minus the full band
  localparam int unsigned THR_W = 14;

  // register index, taken from paddr[4:2]
  localparam logic [2:0] REG_CTRL_EN   = 3'd0;
  localparam logic [2:0] REG_TARGET    = 3'd1;
  localparam logic [2:0] REG_BAND      = 3'd2;
  localparam logic [2:0] REG_VALVE_LCK = 3'd3;
  localparam logic [2:0] REG_COMP_LCK  = 3'd4;

  localparam logic [FAN_W-1:0] FAN_FULL = 8'd255;
  localparam logic [FAN_W-1:0] FAN_OFF  = 8'd0;

  localparam logic signed [TEMP_W-1:0] TARGET_RST = 12'sd320;  // 20.0 degC
  localparam logic [BAND_W-1:0]        BAND_RST   = 11'd16;
  localparam logic [TIMER_W-1:0]       VALVE_LCK_RST = 32'd60000;
  localparam logic [TIMER_W-1:0]       COMP_LCK_RST  = 32'd180000;

  typedef struct packed {
    logic                       ctrl_en;
    logic signed [TEMP_W-1:0]   target;
    logic [BAND_W-1:0]          band;
    logic [TIMER_W-1:0]         valve_lck;
    logic [TIMER_W-1:0]         comp_lck;
  } chl_cfg_t;

endpackage

>>> design/chl_regs.sv
// APB-style configuration register file for the chiller controller.
`timescale 1ns / 1ps
module chl_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [chl_pkg::ADDR_W-1:0]   paddr,
  input  logic [chl_pkg::DATA_W-1:0]   pwdata,
  output logic [chl_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output chl_pkg::chl_cfg_t            cfg
);
  import chl_pkg::*;

  chl_cfg_t   cfg_r;
  chl_cfg_t   cfg_nxt;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:2];
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_CTRL_EN:   cfg_nxt.ctrl_en   = pwdata[0];
        REG_TARGET:    cfg_nxt.target    = pwdata[TEMP_W-1:0];
        REG_BAND:      cfg_nxt.band      = pwdata[BAND_W-1:0];
        REG_VALVE_LCK: cfg_nxt.valve_lck = pwdata[TIMER_W-1:0];
        REG_COMP_LCK:  cfg_nxt.comp_lck  = pwdata[TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CTRL_EN:   prdata = {{(DATA_W-1){1'b0}}, cfg_r.ctrl_en};
      REG_TARGET:    prdata = {{(DATA_W-TEMP_W){1'b0}}, cfg_r.target};
      REG_BAND:      prdata = {{(DATA_W-BAND_W){1'b0}}, cfg_r.band};
      REG_VALVE_LCK: prdata = cfg_r.valve_lck;
      REG_COMP_LCK:  prdata = cfg_r.comp_lck;
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ctrl_en   <= 1'b1;
      cfg_r.target    <= TARGET_RST;
      cfg_r.band      <= BAND_RST;
      cfg_r.valve_lck <= VALVE_LCK_RST;
      cfg_r.comp_lck  <= COMP_LCK_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> design/chiller_hysteresis_lockout_control_top.sv
// Top level of the chiller thermostat with hysteresis and compressor/valve lockout.
`timescale 1ns / 1ps
// Each request is one control tick. It is captured in an input register, and in the
// cycle it moves on to the result register the timers are advanced (saturating at
// 2^32-1), the hot/cold band tests and lockout compares are made and the relay state
// is updated. The result register is loaded as the tick leaves the input register,
// and one tick is accepted every cycle as long as results are taken; the timer and
// relay state registers are updated as each tick moves on. Configuration must be
// written through the APB-style port only while the block is idle; the block itself
// does not enforce this. The registers sit at byte addresses 0, 4, 8, 12 and 16 in
// the order enable, setpoint, half band, valve lockout, compressor lockout.
module chiller_hysteresis_lockout_control_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [chl_pkg::DELTA_W-1:0]         in_delta_ms,
  input  logic signed [chl_pkg::TEMP_W-1:0]   in_water_temp,
  input  logic                                in_pump_running,
  input  logic                                in_flow_present,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_compressor_on,
  output logic                                out_valve_open,
  output logic [chl_pkg::FAN_W-1:0]           out_fan_drive,
  output logic [chl_pkg::TIMER_W-1:0]         out_compressor_elapsed,
  output logic [chl_pkg::TIMER_W-1:0]         out_valve_elapsed,
  output logic                                out_no_flow_fault,
  output logic                                out_alarm_latched,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [chl_pkg::ADDR_W-1:0]          paddr,
  input  logic [chl_pkg::DATA_W-1:0]          pwdata,
  output logic [chl_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);
  import chl_pkg::*;

  chl_cfg_t cfg;

  chl_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register
  logic                      in_v_r;
  logic [DELTA_W-1:0]        delta_r;
  logic signed [TEMP_W-1:0]  water_r;
  logic                      pump_r;
  logic                      flow_r;

  // controller state
  logic [TIMER_W-1:0] comp_tmr_r, comp_tmr_nxt;
  logic [TIMER_W-1:0] valve_tmr_r, valve_tmr_nxt;
  logic               comp_on_r, comp_on_nxt;
  logic               valve_on_r, valve_on_nxt;
  logic [FAN_W-1:0]   fan_r, fan_nxt;
  logic               alarm_r, alarm_nxt;
  logic               fault_nxt;

  // result register
  logic               out_v_r;
  logic               res_comp_r;
  logic               res_valve_r;
  logic [FAN_W-1:0]   res_fan_r;
  logic [TIMER_W-1:0] res_comp_tmr_r;
  logic [TIMER_W-1:0] res_valve_tmr_r;
  logic               res_fault_r;
  logic               res_alarm_r;

  logic               out_free;
  logic               advance;

  logic [TIMER_W:0]          comp_sum;
  logic [TIMER_W:0]          valve_sum;
  logic [TIMER_W-1:0]        comp_seen;
  logic [TIMER_W-1:0]        valve_seen;
  logic signed [THR_W-1:0]   water_x;
  logic signed [THR_W-1:0]   tgt_x;
  logic signed [THR_W-1:0]   band_x;
  logic signed [THR_W-1:0]   hi_thr;
  logic signed [THR_W-1:0]   lo_thr;
  logic                      hot;
  logic                      cold;

  assign out_free = !out_v_r || out_ready;
  assign advance  = in_v_r && out_free;
  assign in_ready = !in_v_r || out_free;

  assign comp_sum   = {1'b0, comp_tmr_r} + {{(TIMER_W+1-DELTA_W){1'b0}}, delta_r};
  assign valve_sum  = {1'b0, valve_tmr_r} + {{(TIMER_W+1-DELTA_W){1'b0}}, delta_r};
  assign comp_seen  = comp_sum[TIMER_W] ? '1 : comp_sum[TIMER_W-1:0];
  assign valve_seen = valve_sum[TIMER_W] ? '1 : valve_sum[TIMER_W-1:0];

  assign water_x = {{(THR_W-TEMP_W){water_r[TEMP_W-1]}}, water_r};
  assign tgt_x   = {{(THR_W-TEMP_W){cfg.target[TEMP_W-1]}}, cfg.target};
  assign band_x  = {{(THR_W-BAND_W){1'b0}}, cfg.band};
  assign hi_thr  = tgt_x + band_x;
  assign lo_thr  = tgt_x - band_x;
  assign hot     = water_x > hi_thr;
  assign cold    = water_x <= lo_thr;

  // hot and cold cannot both hold since the band is never negative
  always_comb begin
    comp_tmr_nxt  = comp_seen;
    valve_tmr_nxt = valve_seen;
    comp_on_nxt   = comp_on_r;
    valve_on_nxt  = valve_on_r;
    fan_nxt       = fan_r;
    alarm_nxt     = alarm_r;
    fault_nxt     = 1'b0;
    if (cfg.ctrl_en) begin
      if (hot) begin
        if (!valve_on_r) begin
          valve_on_nxt  = 1'b1;
          valve_tmr_nxt = '0;
        end
        // lockouts judged on the pre-change timers
        if (valve_seen >= cfg.valve_lck && comp_seen >= cfg.comp_lck) begin
          comp_on_nxt  = 1'b1;
          fan_nxt      = FAN_FULL;
          comp_tmr_nxt = '0;
        end
      end
      if (cold && comp_seen >= cfg.comp_lck) begin
        comp_on_nxt   = 1'b0;
        valve_on_nxt  = 1'b0;
        fan_nxt       = FAN_OFF;
        comp_tmr_nxt  = '0;
        valve_tmr_nxt = '0;
      end
      if (pump_r && !flow_r) begin
        fault_nxt = 1'b1;
        alarm_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      comp_tmr_r  <= '0;
      valve_tmr_r <= '0;
      comp_on_r   <= 1'b0;
      valve_on_r  <= 1'b0;
      fan_r       <= FAN_OFF;
      alarm_r     <= 1'b0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (advance) begin
        out_v_r     <= 1'b1;
        comp_tmr_r  <= comp_tmr_nxt;
        valve_tmr_r <= valve_tmr_nxt;
        comp_on_r   <= comp_on_nxt;
        valve_on_r  <= valve_on_nxt;
        fan_r       <= fan_nxt;
        alarm_r     <= alarm_nxt;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      delta_r <= in_delta_ms;
      water_r <= in_water_temp;
      pump_r  <= in_pump_running;
      flow_r  <= in_flow_present;
    end
    if (advance) begin
      res_comp_r      <= comp_on_nxt;
      res_valve_r     <= valve_on_nxt;
      res_fan_r       <= fan_nxt;
      res_comp_tmr_r  <= comp_seen;
      res_valve_tmr_r <= valve_seen;
      res_fault_r     <= fault_nxt;
      res_alarm_r     <= alarm_nxt;
    end
  end

  assign out_valid              = out_v_r;
  assign out_compressor_on      = res_comp_r;
  assign out_valve_open         = res_valve_r;
  assign out_fan_drive          = res_fan_r;
  assign out_compressor_elapsed = res_comp_tmr_r;
  assign out_valve_elapsed      = res_valve_tmr_r;
  assign out_no_flow_fault      = res_fault_r;
  assign out_alarm_latched      = res_alarm_r;

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the chiller hysteresis and lockout controller.
`timescale 1ns / 1ps
module tb;
  import chl_pkg::*;

  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned STALL_CYCLES = 300;
  localparam int unsigned SAT_TICKS    = 20;
  localparam int unsigned REPORT_CAP   = 200;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_TICKS  = 100;
  localparam int          TEMP_MIN     = -880;
  localparam int          TEMP_MAX     = 2000;
  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

  typedef struct packed {
    logic [DELTA_W-1:0]       delta_ms;
    logic signed [TEMP_W-1:0] water_temp;
    logic                     pump_running;
    logic                     flow_present;
  } tick_t;

  typedef struct packed {
    logic                 compressor_on;
    logic                 valve_open;
    logic [FAN_W-1:0]     fan_drive;
    logic [TIMER_W-1:0]   compressor_elapsed;
    logic [TIMER_W-1:0]   valve_elapsed;
    logic                 no_flow_fault;
    logic                 alarm_latched;
  } relay_report_t;

  typedef enum int {HOT_RUN, COLD_RUN, DEAD_BAND, NOISE} temp_region_e;

  // Tracks relay and timer state, queues the report due for each request.
  class relay_tracker;
    bit                       ctrl_en;
    logic signed [TEMP_W-1:0] setpoint;
    logic [BAND_W-1:0]        half_band;
    logic [TIMER_W-1:0]       valve_lck_ms;
    logic [TIMER_W-1:0]       comp_lck_ms;
    logic [TIMER_W-1:0]       comp_ms;
    logic [TIMER_W-1:0]       valve_ms;
    bit                       comp_on;
    bit                       valve_on;
    bit                       alarm;
    logic [FAN_W-1:0]         fan;
    relay_report_t            reports_due[$];
    int unsigned              errors;
    int unsigned              reports_checked;
    int unsigned              comp_starts;
    int unsigned              faults;

    function new();
      ctrl_en = 1'b1;
      setpoint = TARGET_RST;
      half_band = BAND_RST;
      valve_lck_ms = VALVE_LCK_RST;
      comp_lck_ms = COMP_LCK_RST;
      comp_ms = '0;
      valve_ms = '0;
      comp_on = 1'b0;
      valve_on = 1'b0;
      alarm = 1'b0;
      fan = FAN_OFF;
      errors = 0;
      reports_checked = 0;
      comp_starts = 0;
      faults = 0;
    endfunction

    function logic [TIMER_W-1:0] sat_add(logic [TIMER_W-1:0] a, logic [DELTA_W-1:0] b);
      logic [TIMER_W:0] s;
      s = {1'b0, a} + b;
      return s[TIMER_W] ? TIMER_MAX : s[TIMER_W-1:0];
    endfunction

    function void set_reg(logic [2:0] idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_CTRL_EN:   ctrl_en = value[0];
        REG_TARGET:    setpoint = value[TEMP_W-1:0];
        REG_BAND:      half_band = value[BAND_W-1:0];
        REG_VALVE_LCK: valve_lck_ms = value[TIMER_W-1:0];
        REG_COMP_LCK:  comp_lck_ms = value[TIMER_W-1:0];
        default: ;
      endcase
    endfunction

    function void accept_tick(tick_t t);
      relay_report_t      r;
      logic [TIMER_W-1:0] comp_seen;
      logic [TIMER_W-1:0] valve_seen;
      int                 water;
      int                 sp;
      int                 bw;
      bit                 was_on;
      comp_ms = sat_add(comp_ms, t.delta_ms);
      valve_ms = sat_add(valve_ms, t.delta_ms);
      comp_seen = comp_ms;
      valve_seen = valve_ms;
      water = $signed(t.water_temp);
      sp = setpoint;
      bw = half_band;
      was_on = comp_on;
      r.no_flow_fault = 1'b0;
      if (ctrl_en) begin
        if (water > sp + bw) begin
          if (!valve_on) begin
            valve_on = 1'b1;
            valve_ms = '0;
          end
          // lockouts judged on the counts reported for this tick
          if (valve_seen >= valve_lck_ms && comp_seen >= comp_lck_ms) begin
            comp_on = 1'b1;
            fan = FAN_FULL;
            comp_ms = '0;
          end
        end
        if (water <= sp - bw && comp_ms >= comp_lck_ms) begin
          comp_on = 1'b0;
          valve_on = 1'b0;
          fan = FAN_OFF;
          comp_ms = '0;
          valve_ms = '0;
        end
        if (t.pump_running && !t.flow_present) begin
          r.no_flow_fault = 1'b1;
          alarm = 1'b1;
          faults++;
        end
      end
      if (comp_on && !was_on) comp_starts++;
      r.compressor_on = comp_on;
      r.valve_open = valve_on;
      r.fan_drive = fan;
      r.compressor_elapsed = comp_seen;
      r.valve_elapsed = valve_seen;
      r.alarm_latched = alarm;
      reports_due.push_back(r);
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_report(relay_report_t got);
      relay_report_t want;
      if (reports_due.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: result with no request pending, expected none, actual %p",
                   $time, got);
        return;
      end
      want = reports_due.pop_front();
      reports_checked++;
      compare_field("compressor_on", want.compressor_on, got.compressor_on);
      compare_field("valve_open", want.valve_open, got.valve_open);
      compare_field("fan_drive", want.fan_drive, got.fan_drive);
      compare_field("compressor_elapsed", want.compressor_elapsed, got.compressor_elapsed);
      compare_field("valve_elapsed", want.valve_elapsed, got.valve_elapsed);
      compare_field("no_flow_fault", want.no_flow_fault, got.no_flow_fault);
      compare_field("alarm_latched", want.alarm_latched, got.alarm_latched);
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n = 1'b0;
  logic                      in_valid;
  logic                      in_ready;
  logic [DELTA_W-1:0]        in_delta_ms;
  logic signed [TEMP_W-1:0]  in_water_temp;
  logic                      in_pump_running;
  logic                      in_flow_present;
  logic                      out_valid;
  logic                      out_ready;
  logic                      out_compressor_on;
  logic                      out_valve_open;
  logic [FAN_W-1:0]          out_fan_drive;
  logic [TIMER_W-1:0]        out_compressor_elapsed;
  logic [TIMER_W-1:0]        out_valve_elapsed;
  logic                      out_no_flow_fault;
  logic                      out_alarm_latched;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [ADDR_W-1:0]         paddr;
  logic [DATA_W-1:0]         pwdata;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;

  relay_tracker sb = new();

  bit           idle_on = 1'b1;
  bit           stall_request = 1'b0;
  int           cur_sp = 320;
  int           cur_bw = 16;
  temp_region_e region = DEAD_BAND;
  int           run_left = 0;
  int unsigned  ticks_sent = 0;
  int unsigned  settings_used = 1;
  int unsigned  quiet_cycles = 0;

  chiller_hysteresis_lockout_control_top DUT (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog: too long without any request moving on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, giving up", $time, QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_tick(tick_t t, int unsigned gap);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_delta_ms = t.delta_ms;
    in_water_temp = t.water_temp;
    in_pump_running = t.pump_running;
    in_flow_present = t.flow_present;
    do @(posedge clk); while (!in_ready);
    sb.accept_tick(t);
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic tick(int delta, int water, bit pump, bit flow);
    tick_t t;
    t.delta_ms = delta[DELTA_W-1:0];
    t.water_temp = water[TEMP_W-1:0];
    t.pump_running = pump;
    t.flow_present = flow;
    send_tick(t, idle_on ? $urandom_range(0, 15) : 0);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [DATA_W-1:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, value);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic apply_settings(bit en, int sp, int bw,
                                logic [TIMER_W-1:0] v_lck, logic [TIMER_W-1:0] c_lck);
    in_valid = 1'b0;
    while (sb.reports_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    write_reg(REG_CTRL_EN, 32'(en));
    write_reg(REG_TARGET, 32'(sp));
    write_reg(REG_BAND, 32'(bw));
    write_reg(REG_VALVE_LCK, v_lck);
    write_reg(REG_COMP_LCK, c_lck);
    cur_sp = sp;
    cur_bw = bw;
    settings_used++;
  endtask

  // Runs of hot, cold and in-band readings so the relays actually cycle;
  // occasional readings anywhere in range as noise.
  function automatic tick_t random_tick();
    tick_t t;
    int    w;
    int    k;
    if (run_left == 0) begin
      k = $urandom_range(0, 9);
      if (k == 0) region = NOISE;
      else if (k < 4) region = DEAD_BAND;
      else if (k < 7) region = HOT_RUN;
      else region = COLD_RUN;
      run_left = (region == NOISE) ? 1 : $urandom_range(1, 8);
    end
    run_left--;
    case (region)
      HOT_RUN:   w = cur_sp + cur_bw + 1 + int'($urandom_range(0, 150));
      COLD_RUN:  w = cur_sp - cur_bw - int'($urandom_range(0, 150));
      DEAD_BAND: w = (cur_bw == 0) ? cur_sp :
                     cur_sp - cur_bw + 1 + int'($urandom_range(0, 2 * cur_bw - 1));
      default:   w = TEMP_MIN + int'($urandom_range(0, TEMP_MAX - TEMP_MIN));
    endcase
    if (w > TEMP_MAX) w = TEMP_MAX;
    if (w < TEMP_MIN) w = TEMP_MIN;
    t.water_temp = w[TEMP_W-1:0];
    k = $urandom_range(0, 9);
    if (k == 0) t.delta_ms = '0;
    else if (k == 1) t.delta_ms = '1;
    else if (k < 4) t.delta_ms = 16'($urandom_range(0, 100));
    else t.delta_ms = 16'($urandom_range(0, 65535));
    k = $urandom_range(0, 9);
    if (k == 0) begin
      t.pump_running = 1'b1;
      t.flow_present = 1'b0;
    end else begin
      t.pump_running = 1'($urandom_range(0, 1));
      t.flow_present = t.pump_running ? 1'b1 : 1'($urandom_range(0, 1));
    end
    return t;
  endfunction

  function automatic logic [TIMER_W-1:0] pick_lockout();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return '0;
    if (k == 1) return TIMER_MAX;
    if (k == 2) return $urandom;
    return $urandom_range(0, 250000);
  endfunction

  function automatic int pick_band();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 0;
    if (k == 1) return 1600;
    if (k == 2) return $urandom_range(0, 1600);
    return $urandom_range(0, 64);
  endfunction

  task automatic run_random_phase(int unsigned p);
    int sp;
    case (p)
      0: apply_settings(1'b1, 320, 16, VALVE_LCK_RST, COMP_LCK_RST);
      1: apply_settings(1'b1, TEMP_MIN, 1600, '0, '0);
      2: apply_settings(1'b1, TEMP_MAX, 0, pick_lockout(), pick_lockout());
      3: apply_settings(1'b0, 320, pick_band(), pick_lockout(), pick_lockout());
      default: begin
        sp = TEMP_MIN + int'($urandom_range(0, TEMP_MAX - TEMP_MIN));
        apply_settings(1'b1, sp, pick_band(), pick_lockout(), pick_lockout());
      end
    endcase
    for (int unsigned i = 0; i < PHASE_TICKS; i++) begin
      if (i % 25 == 0) idle_on = ($urandom_range(0, 3) != 0);
      // long output stall while requests keep coming
      if (p == 5 && i == 20) stall_request = 1'b1;
      send_tick(random_tick(), idle_on ? $urandom_range(0, 15) : 0);
    end
  endtask

  initial begin : result_sink
    relay_report_t got;
    int unsigned   gap;
    wait (rst_n === 1'b1);
    forever begin
      if (stall_request) begin
        stall_request = 1'b0;
        out_ready = 1'b0;
        repeat (STALL_CYCLES) @(negedge clk);
      end
      gap = idle_on ? $urandom_range(0, 15) : 0;
      if (gap != 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      got.compressor_on = out_compressor_on;
      got.valve_open = out_valve_open;
      got.fan_drive = out_fan_drive;
      got.compressor_elapsed = out_compressor_elapsed;
      got.valve_elapsed = out_valve_elapsed;
      got.no_flow_fault = out_no_flow_fault;
      got.alarm_latched = out_alarm_latched;
      sb.check_report(got);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    tick_t hot_max;
    in_valid = 1'b0;
    in_delta_ms = '0;
    in_water_temp = '0;
    in_pump_running = 1'b0;
    in_flow_present = 1'b0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset settings: hot above 336, cold at or below 304
    tick(0, 320, 0, 0);
    tick(65535, TEMP_MAX, 0, 1);
    tick(65535, 337, 0, 1);
    tick(65535, 336, 0, 1);
    tick(0, 337, 0, 1);
    tick(1000, TEMP_MIN, 0, 0);
    tick(65535, 305, 0, 0);
    tick(65535, 304, 1, 1);
    tick(65535, 304, 1, 1);
    tick(0, TEMP_MAX, 0, 0);
    tick(12, -1, 1, 1);
    tick(1, 0, 0, 0);
    tick(43690, 1365, 1, 0);
    tick(21845, 320, 0, 0);
    tick(65535, TEMP_MAX, 1, 1);

    // control off: no faults, relays hold; both timers keep running back to back
    apply_settings(1'b0, 320, 16, VALVE_LCK_RST, COMP_LCK_RST);
    tick(100, TEMP_MAX, 1, 0);
    tick(100, TEMP_MIN, 0, 1);
    idle_on = 1'b0;
    hot_max.delta_ms = '1;
    hot_max.water_temp = TEMP_MAX[TEMP_W-1:0];
    hot_max.pump_running = 1'b0;
    hot_max.flow_present = 1'b1;
    repeat (SAT_TICKS) send_tick(hot_max, 0);
    idle_on = 1'b1;

    // the largest lockouts keep the compressor from starting or stopping
    apply_settings(1'b1, TEMP_MIN, 0, TIMER_MAX, TIMER_MAX);
    tick(0, TEMP_MAX, 0, 1);
    tick(65535, TEMP_MIN, 0, 1);
    tick(0, TEMP_MIN + 1, 0, 1);

    // zero lockouts at both setpoint extremes with the widest band
    apply_settings(1'b1, TEMP_MAX, 1600, '0, '0);
    tick(0, 400, 1, 1);
    tick(0, TEMP_MAX, 1, 1);
    tick(0, 401, 1, 1);
    apply_settings(1'b1, TEMP_MIN, 1600, '0, '0);
    tick(0, 721, 0, 0);
    tick(0, 720, 0, 0);

    for (int unsigned p = 0; p < PHASES; p++) run_random_phase(p);

    in_valid = 1'b0;
    while (sb.reports_due.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    $display("Covered %0d control ticks under %0d register settings, %0d results checked.",
             ticks_sent, settings_used, sb.reports_checked);
    $display("Predicted %0d compressor starts and %0d no-flow faults, with a long output stall.",
             sb.comp_starts, sb.faults);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
design/chl_pkg.sv
design/chl_regs.sv
design/chiller_hysteresis_lockout_control_top.sv
tb/sv/tb.sv
